// ===== rtl/core/tbhd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbhd_pkg
// Shared types and constants for the tape block header decoder: word
// layouts of both channels, header formats, block kinds and status codes.
// ----------------------------------------------------------------------------
package tbhd_pkg;

  localparam int unsigned LONG_HEADER_BYTES  = 17;
  localparam int unsigned SHORT_HEADER_BYTES = 8;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned INDEX_W = 1;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_HEADER_FORMAT      = 1'd0;
  localparam logic [INDEX_W-1:0] REG_LIMIT_BLOCK_NUMBER = 1'd1;

  // flag byte bits
  localparam int unsigned FLAG_LOCKED    = 0;
  localparam int unsigned FLAG_NOT_FIRST = 5;
  localparam int unsigned FLAG_DATA      = 6;
  localparam int unsigned FLAG_LAST      = 7;

  typedef enum logic [1:0] {
    FMT_LONG  = 2'd0,
    FMT_SHORT = 2'd1,
    FMT_BAD2  = 2'd2,
    FMT_BAD3  = 2'd3
  } format_t;

  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_MIDDLE = 2'd1,
    KIND_LAST   = 2'd2,
    KIND_SINGLE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_TOO_SHORT   = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       final_byte;
  } header_word_t;

  typedef struct packed {
    logic [31:0] load_address;
    logic [31:0] exec_address;
    logic [31:0] next_address;
    logic [15:0] block_number;
    logic [15:0] block_size;
    logic [1:0]  block_kind;
    logic        is_locked;
    logic [1:0]  status;
  } result_word_t;

endpackage

// ===== rtl/core/tape_block_header_decoder.sv =====
// ----------------------------------------------------------------------------
// tape_block_header_decoder
// Collects cassette block header bytes into field registers and decodes
// the header, long little-endian or short big-endian, on its last byte.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    word
//  header    in         header_valid / header_stall  header_byte, final_byte
//  result    out        result_valid / result_stall  addresses, size, kind ...
//  cfg       in         cfg_write_enable             cfg_index, cfg_data
//
//  one byte a cycle while header_stall is low; a result appears in the cycle after its last byte
//  rst clears the format registers, field registers and the result valid
//  the result register holds a word until taken; header_stall rises only
//  while a result waits under result_stall
// ----------------------------------------------------------------------------
module tape_block_header_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            header_valid,
  output logic                            header_stall,
  input  tbhd_pkg::header_word_t          header,
  output logic                            result_valid,
  input  logic                            result_stall,
  output tbhd_pkg::result_word_t          result,
  input  logic                            cfg_write_enable,
  input  logic [tbhd_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [tbhd_pkg::CFG_W-1:0]      cfg_data
);

  tbhd_pkg::format_t              header_format;
  logic                           limit_block_number;

  logic [tbhd_pkg::POS_W-1:0]     byte_position, byte_position_next;
  logic [31:0]                    load_field, load_field_next;
  logic [31:0]                    exec_field, exec_field_next;
  logic [31:0]                    next_field, next_field_next;
  logic [15:0]                    number_field, number_field_next;
  logic [15:0]                    length_field, length_field_next;
  logic [7:0]                     flag_field, flag_field_next;

  tbhd_pkg::result_word_t         result_next;
  logic                           accept;
  logic [7:0]                     b;
  logic [tbhd_pkg::POS_W-1:0]     pos;
  logic [1:0]                     next_lane;
  logic [15:0]                    num;
  logic                           too_short;

  assign header_stall = result_valid & result_stall;
  assign accept       = header_valid & ~header_stall;
  assign b            = header.header_byte;
  assign pos          = byte_position;
  assign next_lane    = pos[1:0] - 2'd1;

  // field store
  always_comb begin
    load_field_next   = load_field;
    exec_field_next   = exec_field;
    next_field_next   = next_field;
    number_field_next = number_field;
    length_field_next = length_field;
    flag_field_next   = flag_field;
    if (header_format == tbhd_pkg::FMT_LONG) begin
      if (pos < 5'd4) begin
        load_field_next[pos[1:0]*8 +: 8] = b;
      end else if (pos < 5'd8) begin
        exec_field_next[pos[1:0]*8 +: 8] = b;
      end else if (pos < 5'd10) begin
        number_field_next[pos[0]*8 +: 8] = b;
      end else if (pos < 5'd12) begin
        length_field_next[pos[0]*8 +: 8] = b;
      end else if (pos == 5'd12) begin
        flag_field_next = b;
      end else if (pos < 5'd17) begin
        next_field_next[next_lane*8 +: 8] = b;
      end
    end else if (header_format == tbhd_pkg::FMT_SHORT) begin
      case (pos)
        5'd0: flag_field_next = b;
        5'd1: number_field_next[15:8] = b;
        5'd2: number_field_next[7:0] = b;
        5'd3: length_field_next = {8'd0, b};
        5'd4: exec_field_next = {16'd0, b, exec_field[7:0]};
        5'd5: exec_field_next = {16'd0, exec_field[15:8], b};
        5'd6: load_field_next = {16'd0, b, load_field[7:0]};
        5'd7: load_field_next = {16'd0, load_field[15:8], b};
        default: ;
      endcase
    end
    byte_position_next = (pos == 5'd31) ? pos : pos + 5'd1;
  end

  // decode
  always_comb begin
    num       = limit_block_number ? {8'd0, number_field_next[7:0]} : number_field_next;
    too_short = (header_format == tbhd_pkg::FMT_LONG)
              ? (byte_position_next < 5'(tbhd_pkg::LONG_HEADER_BYTES))
              : (byte_position_next < 5'(tbhd_pkg::SHORT_HEADER_BYTES));
    result_next = '0;
    if (header_format == tbhd_pkg::FMT_BAD2 || header_format == tbhd_pkg::FMT_BAD3) begin
      result_next.status = tbhd_pkg::STATUS_UNSUPPORTED;
    end else if (too_short) begin
      result_next.status = tbhd_pkg::STATUS_TOO_SHORT;
    end else begin
      result_next.status       = tbhd_pkg::STATUS_OK;
      result_next.block_number = num;
      result_next.load_address = load_field_next;
      result_next.exec_address = exec_field_next;
      if (header_format == tbhd_pkg::FMT_LONG) begin
        result_next.next_address = next_field_next;
        result_next.block_size   = flag_field_next[tbhd_pkg::FLAG_DATA] ? 16'd0
                                                                        : length_field_next;
        if (flag_field_next[tbhd_pkg::FLAG_LAST]) begin
          result_next.block_kind = (num == 16'd0) ? tbhd_pkg::KIND_SINGLE
                                                  : tbhd_pkg::KIND_LAST;
        end else begin
          result_next.block_kind = (num == 16'd0) ? tbhd_pkg::KIND_FIRST
                                                  : tbhd_pkg::KIND_MIDDLE;
        end
        result_next.is_locked = flag_field_next[tbhd_pkg::FLAG_LOCKED];
      end else begin
        result_next.block_size = flag_field_next[tbhd_pkg::FLAG_DATA]
                               ? {7'd0, {1'b0, length_field_next[7:0]} + 9'd1}
                               : 16'd0;
        if (flag_field_next[tbhd_pkg::FLAG_LAST]) begin
          result_next.block_kind = flag_field_next[tbhd_pkg::FLAG_NOT_FIRST]
                                 ? tbhd_pkg::KIND_MIDDLE : tbhd_pkg::KIND_FIRST;
        end else begin
          result_next.block_kind = flag_field_next[tbhd_pkg::FLAG_NOT_FIRST]
                                 ? tbhd_pkg::KIND_LAST : tbhd_pkg::KIND_SINGLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_format      <= tbhd_pkg::FMT_LONG;
      limit_block_number <= 1'b0;
      byte_position      <= '0;
      load_field         <= '0;
      exec_field         <= '0;
      next_field         <= '0;
      number_field       <= '0;
      length_field       <= '0;
      flag_field         <= '0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          tbhd_pkg::REG_HEADER_FORMAT:      header_format <= tbhd_pkg::format_t'(cfg_data);
          tbhd_pkg::REG_LIMIT_BLOCK_NUMBER: limit_block_number <= cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        if (header.final_byte) begin
          byte_position <= '0;
          load_field    <= '0;
          exec_field    <= '0;
          next_field    <= '0;
          number_field  <= '0;
          length_field  <= '0;
          flag_field    <= '0;
          result_valid  <= 1'b1;
        end else begin
          byte_position <= byte_position_next;
          load_field    <= load_field_next;
          exec_field    <= exec_field_next;
          next_field    <= next_field_next;
          number_field  <= number_field_next;
          length_field  <= length_field_next;
          flag_field    <= flag_field_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && header.final_byte) begin
      result <= result_next;
    end
  end

endmodule

// ===== tb/tb_tape_block_header_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_tape_block_header_decoder
// Self-checking bench for the tape block header decoder. A short table of
// header bytes and register writes covers reset, the extreme header values,
// both formats, short headers and unsupported formats. Random headers follow,
// mostly well formed with random content, plus truncated, overlong and noisy
// ones, with format changes between and inside headers. Every result word is
// checked field by field against its table row or a local header decoder.
// ----------------------------------------------------------------------------
module tb_tape_block_header_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 500;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [tbhd_pkg::INDEX_W-1:0]   idx;
    logic [tbhd_pkg::CFG_W-1:0]     data;
    tbhd_pkg::header_word_t         word;
    tbhd_pkg::result_word_t         want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic header_valid;
  logic header_stall;
  tbhd_pkg::header_word_t header;
  logic result_valid;
  logic result_stall;
  tbhd_pkg::result_word_t result;
  logic cfg_write_enable;
  logic [tbhd_pkg::INDEX_W-1:0] cfg_index;
  logic [tbhd_pkg::CFG_W-1:0] cfg_data;

  // local copy of the decoder state
  tbhd_pkg::format_t hdr_fmt = tbhd_pkg::FMT_LONG;
  logic hdr_limit = 1'b0;
  logic [4:0] hdr_pos = '0;
  logic [31:0] hdr_load = '0;
  logic [31:0] hdr_exec = '0;
  logic [31:0] hdr_next = '0;
  logic [15:0] hdr_num = '0;
  logic [15:0] hdr_len = '0;
  logic [7:0] hdr_flags = '0;

  tbhd_pkg::result_word_t awaited_decodes[$];
  stim_row_t stim_rows[$];
  tbhd_pkg::result_word_t oldest;

  int fails = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int reg_writes = 0;
  int n_ok = 0;
  int n_short = 0;
  int n_unsup = 0;
  int rx_hold = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  tape_block_header_decoder dut (
    .clk              (clk),
    .rst              (rst),
    .header_valid     (header_valid),
    .header_stall     (header_stall),
    .header           (header),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic tbhd_pkg::result_word_t status_only(tbhd_pkg::status_t s);
    tbhd_pkg::result_word_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  task automatic add_row(input stim_row_t row);
    stim_rows.insert(stim_rows.size(), row);
  endtask

  task automatic decode_step(input tbhd_pkg::header_word_t w, output logic emits,
                             output tbhd_pkg::result_word_t r);
    logic [7:0] b;
    logic [15:0] num;
    int p;
    int need;
    b = w.header_byte;
    p = hdr_pos;
    r = '0;
    if (hdr_fmt == tbhd_pkg::FMT_LONG) begin
      if (p < 4) hdr_load[8*p +: 8] = b;
      else if (p < 8) hdr_exec[8*(p-4) +: 8] = b;
      else if (p < 10) hdr_num[8*(p-8) +: 8] = b;
      else if (p < 12) hdr_len[8*(p-10) +: 8] = b;
      else if (p == 12) hdr_flags = b;
      else if (p < 17) hdr_next[8*(p-13) +: 8] = b;
    end else if (hdr_fmt == tbhd_pkg::FMT_SHORT) begin
      case (p)
        0: hdr_flags = b;
        1: hdr_num[15:8] = b;
        2: hdr_num[7:0] = b;
        3: hdr_len = {8'h00, b};
        4: hdr_exec = {16'h0000, b, hdr_exec[7:0]};
        5: hdr_exec = {16'h0000, hdr_exec[15:8], b};
        6: hdr_load = {16'h0000, b, hdr_load[7:0]};
        7: hdr_load = {16'h0000, hdr_load[15:8], b};
        default: ;
      endcase
    end
    if (hdr_pos != 5'd31) hdr_pos = hdr_pos + 5'd1;
    emits = w.final_byte;
    if (!emits) return;

    need = (hdr_fmt == tbhd_pkg::FMT_LONG) ? tbhd_pkg::LONG_HEADER_BYTES
                                           : tbhd_pkg::SHORT_HEADER_BYTES;
    if (hdr_fmt != tbhd_pkg::FMT_LONG && hdr_fmt != tbhd_pkg::FMT_SHORT) begin
      r.status = tbhd_pkg::STATUS_UNSUPPORTED;
    end else if (hdr_pos < need) begin
      r.status = tbhd_pkg::STATUS_TOO_SHORT;
    end else begin
      num = hdr_limit ? {8'h00, hdr_num[7:0]} : hdr_num;
      r.status = tbhd_pkg::STATUS_OK;
      r.block_number = num;
      r.load_address = hdr_load;
      r.exec_address = hdr_exec;
      if (hdr_fmt == tbhd_pkg::FMT_LONG) begin
        r.next_address = hdr_next;
        r.block_size = hdr_flags[tbhd_pkg::FLAG_DATA] ? 16'h0000 : hdr_len;
        if (hdr_flags[tbhd_pkg::FLAG_LAST])
          r.block_kind = (num == 0) ? tbhd_pkg::KIND_SINGLE : tbhd_pkg::KIND_LAST;
        else
          r.block_kind = (num == 0) ? tbhd_pkg::KIND_FIRST : tbhd_pkg::KIND_MIDDLE;
        r.is_locked = hdr_flags[tbhd_pkg::FLAG_LOCKED];
      end else begin
        r.block_size = hdr_flags[tbhd_pkg::FLAG_DATA] ? 16'(hdr_len[7:0]) + 16'd1
                                                      : 16'h0000;
        if (hdr_flags[tbhd_pkg::FLAG_LAST])
          r.block_kind = hdr_flags[tbhd_pkg::FLAG_NOT_FIRST] ? tbhd_pkg::KIND_MIDDLE
                                                             : tbhd_pkg::KIND_FIRST;
        else
          r.block_kind = hdr_flags[tbhd_pkg::FLAG_NOT_FIRST] ? tbhd_pkg::KIND_LAST
                                                             : tbhd_pkg::KIND_SINGLE;
      end
    end
    hdr_pos = '0;
    hdr_load = '0;
    hdr_exec = '0;
    hdr_next = '0;
    hdr_num = '0;
    hdr_len = '0;
    hdr_flags = '0;
  endtask

  // entered and left on a falling edge
  task automatic put_byte(input tbhd_pkg::header_word_t w, input logic use_typed = 1'b0,
                          input tbhd_pkg::result_word_t typed = '0);
    int gap;
    logic emits;
    tbhd_pkg::result_word_t r;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      header_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    header_valid <= 1'b1;
    header <= w;
    @(posedge clk);
    while (header_stall !== 1'b0) @(posedge clk);
    bytes_sent++;
    decode_step(w, emits, r);
    if (emits) awaited_decodes.insert(awaited_decodes.size(), use_typed ? typed : r);
    @(negedge clk);
  endtask

  task automatic settle();
    header_valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tbhd_pkg::INDEX_W-1:0] idx,
                           input logic [tbhd_pkg::CFG_W-1:0] data);
    settle();
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    reg_writes++;
    if (idx == tbhd_pkg::REG_HEADER_FORMAT) hdr_fmt = tbhd_pkg::format_t'(data);
    else hdr_limit = data[0];
  endtask

  function automatic logic [tbhd_pkg::CFG_W-1:0] pick_format();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return tbhd_pkg::FMT_LONG;
    if (r < 8) return tbhd_pkg::FMT_SHORT;
    return (r == 8) ? tbhd_pkg::FMT_BAD2 : tbhd_pkg::FMT_BAD3;
  endfunction

  task automatic random_header();
    int need;
    int shape;
    int len;
    int flip_at;
    tbhd_pkg::header_word_t w;
    need = (hdr_fmt == tbhd_pkg::FMT_SHORT) ? tbhd_pkg::SHORT_HEADER_BYTES
                                            : tbhd_pkg::LONG_HEADER_BYTES;
    shape = $urandom_range(0, 19);
    if (shape < 14) len = need + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    else if (shape < 17) len = $urandom_range(1, need - 1);
    else len = $urandom_range(1, 40);
    flip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == flip_at) write_reg(tbhd_pkg::REG_HEADER_FORMAT, pick_format());
      case ($urandom_range(0, 7))
        0: w.header_byte = 8'h00;
        1: w.header_byte = 8'hFF;
        default: w.header_byte = 8'($urandom_range(0, 255));
      endcase
      w.final_byte = (i == len - 1);
      put_byte(w);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
    end
  endtask

  // result side: when rx_idle, stall at random and while a hold drawn after each word counts down
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      result_stall <= 1'b1;
      rx_hold--;
    end else begin
      result_stall <= rx_idle && ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (awaited_decodes.size() == 0) begin
        fails++;
        $display("%0t: result word with nothing awaited: %p", $time, result);
      end else begin
        oldest = awaited_decodes.pop_front();
        check_field("load_address", oldest.load_address, result.load_address);
        check_field("exec_address", oldest.exec_address, result.exec_address);
        check_field("next_address", oldest.next_address, result.next_address);
        check_field("block_number", 32'(oldest.block_number), 32'(result.block_number));
        check_field("block_size", 32'(oldest.block_size), 32'(result.block_size));
        check_field("block_kind", 32'(oldest.block_kind), 32'(result.block_kind));
        check_field("is_locked", 32'(oldest.is_locked), 32'(result.is_locked));
        check_field("status", 32'(oldest.status), 32'(result.status));
        case (oldest.status)
          tbhd_pkg::STATUS_OK: n_ok++;
          tbhd_pkg::STATUS_TOO_SHORT: n_short++;
          default: n_unsup++;
        endcase
      end
      rx_hold = rx_idle ? $urandom_range(0, 13) : 0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding", $time,
               awaited_decodes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    header_valid = 1'b0;
    header = '0;
    result_stall = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // one byte after reset, long header of all ones, short header, bad format
    add_row('{ROW_TYPED, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'h00, 1'b1},
              status_only(tbhd_pkg::STATUS_TOO_SHORT)});
    for (int i = 0; i < tbhd_pkg::LONG_HEADER_BYTES - 1; i++)
      add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'hFF, 1'b0}, '0});
    add_row('{ROW_TYPED, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'hFF, 1'b1},
              '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                16'h0000, tbhd_pkg::KIND_LAST, 1'b1, tbhd_pkg::STATUS_OK}});
    add_row('{ROW_CFG, tbhd_pkg::REG_LIMIT_BLOCK_NUMBER, 2'd1, '0, '0});
    add_row('{ROW_CFG, tbhd_pkg::REG_HEADER_FORMAT, tbhd_pkg::FMT_SHORT, '0, '0});
    add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'hE0, 1'b0}, '0});
    add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'h12, 1'b0}, '0});
    add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'h34, 1'b0}, '0});
    add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'hFF, 1'b0}, '0});
    add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'hAB, 1'b0}, '0});
    add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'hCD, 1'b0}, '0});
    add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'h80, 1'b0}, '0});
    add_row('{ROW_BYTE, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'h01, 1'b1}, '0});
    add_row('{ROW_CFG, tbhd_pkg::REG_HEADER_FORMAT, tbhd_pkg::FMT_BAD3, '0, '0});
    add_row('{ROW_TYPED, tbhd_pkg::REG_HEADER_FORMAT, '0, '{8'h5A, 1'b1},
              status_only(tbhd_pkg::STATUS_UNSUPPORTED)});
    add_row('{ROW_CFG, tbhd_pkg::REG_LIMIT_BLOCK_NUMBER, 2'd0, '0, '0});
    add_row('{ROW_CFG, tbhd_pkg::REG_HEADER_FORMAT, tbhd_pkg::FMT_LONG, '0, '0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_CFG: write_reg(stim_rows[i].idx, stim_rows[i].data);
        ROW_TYPED: put_byte(stim_rows[i].word, 1'b1, stim_rows[i].want);
        default: put_byte(stim_rows[i].word);
      endcase
    end

    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg(tbhd_pkg::REG_HEADER_FORMAT, pick_format());
        write_reg(tbhd_pkg::REG_LIMIT_BLOCK_NUMBER,
                  tbhd_pkg::CFG_W'($urandom_range(0, 3)));
      end
      random_header();
    end

    header_valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("headers decoded: %0d ok, %0d too short, %0d unsupported format", n_ok,
             n_short, n_unsup);
    $display("header bytes sent: %0d, register writes: %0d, cycles: %0d", bytes_sent,
             reg_writes, cycles);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== tape_block_header_decoder.f =====
rtl/core/tbhd_pkg.sv
rtl/core/tape_block_header_decoder.sv
tb/tb_tape_block_header_decoder.sv
